// ===== src/smoothed_crossfade_wave_generator_top_macros.svh =====
// Assertion macros for the wave generator.
`ifndef SMOOTHED_CROSSFADE_WAVE_GENERATOR_TOP_MACROS_SVH
`define SMOOTHED_CROSSFADE_WAVE_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SCWG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SCWG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCWG_ASSERT(lbl, clk, rst, prop, msg)
`define SCWG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/scwg_pkg.sv =====
package scwg_pkg;

   localparam int SINE_DEPTH = 1024;
   localparam int ROM_AW = $clog2(SINE_DEPTH);
   localparam int PH_W = 32;

   localparam logic [16:0] ONE_Q16 = 17'h10000;
   localparam logic [5:0] TRI_STEPS = 6'd17;
   localparam logic [5:0] INC_STEPS = 6'd48;

   localparam logic [1:0] WAVE_SINE = 2'd0;
   localparam logic [1:0] WAVE_SQUARE = 2'd1;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

   typedef enum logic [2:0] {
      CSR_WAVE_TYPE,
      CSR_FREQ,
      CSR_AMP,
      CSR_OFFSET,
      CSR_DUTY,
      CSR_ALPHA,
      CSR_RATE
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMOOTH,
      ST_MIX,
      ST_EVAL,
      ST_SMUL,
      ST_SFIN,
      ST_TMUL,
      ST_TDIV,
      ST_TFIN,
      ST_BMUL,
      ST_BFIN,
      ST_ISTART,
      ST_IDIV,
      ST_FIN
   } state_type;

   typedef logic [15:0] sine_rom_type [SINE_DEPTH];

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ROM_DIV = 64'(2 * SINE_DEPTH);

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] v;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         x = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) / ROM_DIV;
         x2 = (x * x) >> 30;
         term = x;
         sum = $signed(x);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[k] = v[15:0];
      end
      return rom;
   endfunction

endpackage

// ===== src/smoothed_crossfade_wave_generator_top.sv =====
// A triangle level needs one 17-step division, taken again for the old type in a fade.
// The phase increment is a 48-step restoring division, one quotient bit per cycle.
// A new tick beat is taken only in idle, after the previous one has finished.
// A tick beat of zero is taken and gives no result.
// Synchronous reset clears the control state; no clearing pass is needed.
`include "smoothed_crossfade_wave_generator_top_macros.svh"

module smoothed_crossfade_wave_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_tick,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_wave_value,
   output logic        rsp_fading,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import scwg_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   state_type state_ff, state_in;

   logic [1:0]  wave_type_ff;
   logic [31:0] tgt_freq_ff;
   logic [14:0] tgt_amp_ff;
   logic [15:0] tgt_offset_ff;
   logic [15:0] tgt_duty_ff;
   logic [16:0] alpha_cfg_ff;
   logic [23:0] rate_ff;

   logic [PH_W-1:0] phase_ff;
   logic [31:0] cur_freq_ff;
   logic [14:0] cur_amp_ff;
   logic [15:0] cur_offset_ff;
   logic [15:0] cur_duty_ff;
   logic [16:0] mix_ff;
   logic [1:0]  prev_type_ff;
   logic        primed_ff;

   logic [16:0] alpha_ff;
   logic [1:0]  sel_ff;
   logic        fade_ff;
   logic        eval_prev_ff;
   logic [15:0] rom_q_ff;
   logic [48:0] prod_ff;
   logic signed [18:0] next_lv_ff;
   logic signed [18:0] prev_lv_ff;
   logic signed [18:0] val_ff;

   logic [32:0] div_rem_ff;
   logic [47:0] div_num_ff;
   logic [32:0] div_den_ff;
   logic [47:0] div_q_ff;
   logic [5:0]  div_cnt_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_value_ff;
   logic        rsp_fading_ff;

   logic [31:0] mul_a;
   logic [16:0] mul_b;
   logic [48:0] mul_p;
   logic        lvl_done;
   logic signed [18:0] lvl_val;
   logic        out_load;

   logic [16:0] alpha_eff;
   logic [16:0] mix_eff;
   logic [1:0]  ev_type;

   logic [32:0] sm_cur, sm_tgt, sm_new;
   logic [33:0] sm_diff, sm_neg;
   logic [31:0] sm_mag;

   logic [31:0] rise;
   logic        ph_lt;
   logic [31:0] tri_x;
   logic [32:0] tri_den;
   logic signed [18:0] amp_s, off_s;
   logic [30:0] sin_sum;
   logic signed [18:0] sin_mag;
   logic signed [18:0] tri_q;

   logic signed [19:0] bl_d;
   logic [19:0] bl_neg_d;
   logic [19:0] bl_mag;
   logic signed [37:0] bl_s;
   logic signed [37:0] bl_r;
   logic signed [21:0] bl_v;

   logic [33:0] div_trial;
   logic [33:0] div_shift;
   logic [17:0] mix_sum;
   logic [23:0] fs;
   logic [15:0] sat_val;

   assign alpha_eff = (alpha_cfg_ff == 17'd0 || alpha_cfg_ff > ONE_Q16) ? ONE_Q16 : alpha_cfg_ff;
   assign mix_eff = (wave_type_ff != prev_type_ff && mix_ff == ONE_Q16) ? 17'd0 : mix_ff;
   assign ev_type = eval_prev_ff ? prev_type_ff : wave_type_ff;
   assign fs = (rate_ff == 24'd0) ? 24'd1 : rate_ff;
   assign mix_sum = {1'b0, mix_ff} + {1'b0, alpha_ff};

   always_comb begin
      case (sel_ff)
         2'd0: begin
            sm_cur = {1'b0, cur_freq_ff};
            sm_tgt = {1'b0, tgt_freq_ff};
         end
         2'd1: begin
            sm_cur = {18'd0, cur_amp_ff};
            sm_tgt = {18'd0, tgt_amp_ff};
         end
         2'd2: begin
            sm_cur = {{17{cur_offset_ff[15]}}, cur_offset_ff};
            sm_tgt = {{17{tgt_offset_ff[15]}}, tgt_offset_ff};
         end
         default: begin
            sm_cur = {17'd0, cur_duty_ff};
            sm_tgt = {17'd0, tgt_duty_ff};
         end
      endcase
   end

   assign sm_diff = {sm_tgt[32], sm_tgt} - {sm_cur[32], sm_cur};
   assign sm_neg = 34'd0 - sm_diff;
   assign sm_mag = sm_diff[33] ? sm_neg[31:0] : sm_diff[31:0];
   assign sm_new = sm_diff[33] ? sm_cur - {1'b0, mul_p[47:16]} : sm_cur + {1'b0, mul_p[47:16]};

   assign rise = {cur_duty_ff, 16'd0};
   assign ph_lt = phase_ff < rise;
   assign tri_x = ph_lt ? phase_ff : phase_ff - rise;
   assign tri_den = ph_lt ? {1'b0, rise} : (33'd1 << 32) - {1'b0, rise};
   assign amp_s = $signed({4'd0, cur_amp_ff});
   assign off_s = $signed({{3{cur_offset_ff[15]}}, cur_offset_ff});
   assign sin_sum = prod_ff[30:0] + 31'd16384;
   assign sin_mag = $signed({3'd0, sin_sum[30:15]});
   assign tri_q = $signed({2'd0, div_q_ff[16:0]});

   assign bl_d = $signed({next_lv_ff[18], next_lv_ff}) - $signed({prev_lv_ff[18], prev_lv_ff});
   assign bl_neg_d = 20'd0 - bl_d;
   assign bl_mag = bl_d[19] ? bl_neg_d : bl_d;
   assign bl_s = bl_d[19] ? -$signed({1'b0, prod_ff[36:0]}) : $signed({1'b0, prod_ff[36:0]});
   assign bl_r = (bl_s + 38'sd32768) >>> 16;
   assign bl_v = $signed({{3{prev_lv_ff[18]}}, prev_lv_ff}) + bl_r[21:0];

   assign div_shift = {div_rem_ff, div_num_ff[47]};
   assign div_trial = div_shift - {1'b0, div_den_ff};

   assign mul_p = {17'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      if (val_ff > 19'sd32767) begin
         sat_val = 16'h7FFF;
      end else if (val_ff < -19'sd32768) begin
         sat_val = 16'h8000;
      end else begin
         sat_val = val_ff[15:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_tick) begin
               state_in = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            if (sel_ff == 2'd3) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: state_in = ST_EVAL;
         ST_EVAL: begin
            case (ev_type)
               WAVE_SINE: state_in = ST_SMUL;
               WAVE_TRIANGLE: state_in = ST_TMUL;
               default: state_in = ST_EVAL;
            endcase
         end
         ST_SMUL: state_in = ST_SFIN;
         ST_TMUL: state_in = ST_TDIV;
         ST_TDIV: begin
            if (div_cnt_ff == 6'd1) begin
               state_in = ST_TFIN;
            end
         end
         ST_BMUL: state_in = ST_BFIN;
         ST_BFIN: state_in = ST_ISTART;
         ST_ISTART: state_in = ST_IDIV;
         ST_IDIV: begin
            if (div_cnt_ff == 6'd1) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (lvl_done) begin
         if (!eval_prev_ff && fade_ff) begin
            state_in = ST_EVAL;
         end else if (fade_ff) begin
            state_in = ST_BMUL;
         end else begin
            state_in = ST_ISTART;
         end
      end
   end

   always_comb begin
      req_stall = 1'b1;
      mul_a = 32'd0;
      mul_b = 17'd0;
      lvl_done = 1'b0;
      lvl_val = 19'sd0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_SMOOTH: begin
            mul_a = sm_mag;
            mul_b = alpha_ff;
         end
         ST_EVAL: begin
            case (ev_type)
               WAVE_SQUARE: begin
                  lvl_done = 1'b1;
                  lvl_val = (ph_lt ? amp_s : -amp_s) + off_s;
               end
               WAVE_SINE, WAVE_TRIANGLE: lvl_done = 1'b0;
               default: begin
                  lvl_done = 1'b1;
                  lvl_val = 19'sd0;
               end
            endcase
         end
         ST_SMUL: begin
            mul_a = {17'd0, cur_amp_ff};
            mul_b = {1'b0, rom_q_ff};
         end
         ST_SFIN: begin
            lvl_done = 1'b1;
            lvl_val = (phase_ff[PH_W-1] ? -sin_mag : sin_mag) + off_s;
         end
         ST_TMUL: begin
            mul_a = tri_x;
            mul_b = {1'b0, cur_amp_ff, 1'b0};
         end
         ST_TFIN: begin
            lvl_done = 1'b1;
            lvl_val = (ph_lt ? tri_q - amp_s : amp_s - tri_q) + off_s;
         end
         ST_BMUL: begin
            mul_a = {12'd0, bl_mag};
            mul_b = mix_ff;
         end
         ST_FIN: out_load = !rsp_valid_ff || !rsp_stall;
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wave_type_ff <= WAVE_SINE;
         tgt_freq_ff <= 32'd0;
         tgt_amp_ff <= 15'd0;
         tgt_offset_ff <= 16'd0;
         tgt_duty_ff <= 16'd32768;
         alpha_cfg_ff <= 17'd0;
         rate_ff <= 24'd48000;
         phase_ff <= '0;
         cur_freq_ff <= 32'd0;
         cur_amp_ff <= 15'd0;
         cur_offset_ff <= 16'd0;
         cur_duty_ff <= 16'd0;
         mix_ff <= 17'd0;
         prev_type_ff <= WAVE_SINE;
         primed_ff <= 1'b0;
         sel_ff <= 2'd0;
         fade_ff <= 1'b0;
         eval_prev_ff <= 1'b0;
         div_cnt_ff <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WAVE_TYPE: wave_type_ff <= csr_wdata[1:0];
               CSR_FREQ: tgt_freq_ff <= csr_wdata;
               CSR_AMP: tgt_amp_ff <= csr_wdata[14:0];
               CSR_OFFSET: tgt_offset_ff <= csr_wdata[15:0];
               CSR_DUTY: tgt_duty_ff <= csr_wdata[15:0];
               CSR_ALPHA: alpha_cfg_ff <= csr_wdata[16:0];
               CSR_RATE: rate_ff <= csr_wdata[23:0];
               default: rate_ff <= rate_ff;
            endcase
         end
         rsp_valid_ff <= out_load || (rsp_valid_ff && rsp_stall);
         case (state_ff)
            ST_IDLE: begin
               sel_ff <= 2'd0;
               if (req_valid && req_tick && !primed_ff) begin
                  primed_ff <= 1'b1;
                  cur_freq_ff <= tgt_freq_ff;
                  cur_amp_ff <= tgt_amp_ff;
                  cur_offset_ff <= tgt_offset_ff;
                  cur_duty_ff <= tgt_duty_ff;
               end
            end
            ST_SMOOTH: begin
               sel_ff <= sel_ff + 2'd1;
               case (sel_ff)
                  2'd0: cur_freq_ff <= sm_new[31:0];
                  2'd1: cur_amp_ff <= sm_new[14:0];
                  2'd2: cur_offset_ff <= sm_new[15:0];
                  default: cur_duty_ff <= sm_new[15:0];
               endcase
            end
            ST_MIX: begin
               mix_ff <= mix_eff;
               fade_ff <= (mix_eff != ONE_Q16);
               eval_prev_ff <= 1'b0;
            end
            ST_TMUL: begin
               div_rem_ff <= {2'd0, mul_p[47:17]};
               div_num_ff <= {mul_p[16:0], 31'd0};
               div_den_ff <= tri_den;
               div_q_ff <= 48'd0;
               div_cnt_ff <= TRI_STEPS;
            end
            ST_ISTART: begin
               div_rem_ff <= 33'd0;
               div_num_ff <= {cur_freq_ff, 16'd0};
               div_den_ff <= {9'd0, fs};
               div_q_ff <= 48'd0;
               div_cnt_ff <= INC_STEPS;
            end
            ST_TDIV, ST_IDIV: begin
               div_rem_ff <= div_trial[33] ? div_shift[32:0] : div_trial[32:0];
               div_num_ff <= {div_num_ff[46:0], 1'b0};
               div_q_ff <= {div_q_ff[46:0], !div_trial[33]};
               div_cnt_ff <= div_cnt_ff - 6'd1;
            end
            ST_FIN: begin
               if (out_load) begin
                  phase_ff <= phase_ff + div_q_ff[PH_W-1:0];
                  if (fade_ff) begin
                     if (mix_sum >= {1'b0, ONE_Q16}) begin
                        mix_ff <= ONE_Q16;
                        prev_type_ff <= wave_type_ff;
                     end else begin
                        mix_ff <= mix_sum[16:0];
                     end
                  end else begin
                     prev_type_ff <= wave_type_ff;
                  end
               end
            end
            default: sel_ff <= sel_ff;
         endcase
         if (lvl_done && !eval_prev_ff && fade_ff) begin
            eval_prev_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_tick) begin
         alpha_ff <= alpha_eff;
      end
      if (state_ff == ST_EVAL) begin
         rom_q_ff <= SINE_ROM[phase_ff[PH_W-2] ? ~phase_ff[PH_W-3 -: ROM_AW]
                                               : phase_ff[PH_W-3 -: ROM_AW]];
      end
      if (state_ff == ST_SMUL || state_ff == ST_BMUL) begin
         prod_ff <= mul_p;
      end
      if (lvl_done) begin
         if (eval_prev_ff) begin
            prev_lv_ff <= lvl_val;
         end else begin
            next_lv_ff <= lvl_val;
            val_ff <= lvl_val;
         end
      end
      if (state_ff == ST_BFIN) begin
         val_ff <= bl_v[18:0];
      end
      if (out_load) begin
         rsp_value_ff <= sat_val;
         rsp_fading_ff <= fade_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_wave_value = rsp_value_ff;
   assign rsp_fading = rsp_fading_ff;

   `SCWG_ASSERT(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN, "result raised outside the final step")
   `SCWG_ASSERT(a_fade_mix, clock, reset, (state_ff == ST_FIN && fade_ff) |-> mix_ff != ONE_Q16, "fade with finished mix level")
   `SCWG_ASSERT(a_div_count, clock, reset, (state_ff == ST_TDIV || state_ff == ST_IDIV) |-> div_cnt_ff != 6'd0, "divider running with empty count")
   `SCWG_ASSERT_ALWAYS(a_mix_bound, clock, reset || (mix_ff <= ONE_Q16), "mix level beyond one")

endmodule
